@@ rtl/pid_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pid_pkg: shared types and constants of the PID step block
// Widths, command and register codes, request structs and the
// controller to datapath command and status groups.
// ----------------------------------------------------------------------------
package pid_pkg;

    localparam int VALUE_W   = 16;
    localparam int GAIN_W    = 16;
    localparam int FRAC_W    = 8;
    localparam int INTEG_W   = VALUE_W + FRAC_W;
    localparam int MUL_A_W   = 34;
    localparam int MUL_B_W   = GAIN_W + 1;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = 52;
    localparam int DIFF_W    = VALUE_W + 1;
    localparam int QUO_W     = 32;
    localparam int DIV_CNT_W = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

    localparam logic [1:0] CMD_COMPUTE = 2'd0;
    localparam logic [1:0] CMD_MANUAL  = 2'd1;
    localparam logic [1:0] CMD_AUTO    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_P_ON_M  = 2'd2;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [VALUE_W-1:0] measurement;
        logic signed [VALUE_W-1:0] setpoint;
        logic [GAIN_W-1:0]         kp_gain;
        logic [GAIN_W-1:0]         ki_gain;
        logic [GAIN_W-1:0]         kd_gain;
        logic [GAIN_W-1:0]         interval;
        logic signed [VALUE_W-1:0] manual_output;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] drive;
        logic                      computed;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NONE = 4'd0,
        OP_MEI  = 4'd1,
        OP_MIV  = 4'd2,
        OP_ADI  = 4'd3,
        OP_MKP  = 4'd4,
        OP_ADP  = 4'd5,
        OP_CLI  = 4'd6,
        OP_MKD  = 4'd7,
        OP_DVI  = 4'd8,
        OP_DIV  = 4'd9,
        OP_OUT  = 4'd10,
        OP_FIN  = 4'd11
    } t_op;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_dp_cmd;

    typedef struct packed {
        logic compute;
        logic div_done;
    } t_dp_sts;

endpackage
`default_nettype wire

@@ rtl/pid_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pid_dp: PID step datapath
// Request and configuration registers, controller state, one shared
// multiplier, accumulator, clamp logic, a restoring divider and the
// result register.
// ----------------------------------------------------------------------------
module pid_dp import pid_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_in_item             i_in,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [VALUE_W-1:0]   i_cfg_data,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_sts                   o_sts,
    output t_out_item                 o_out
);

    logic signed [VALUE_W-1:0] r_min, r_max;
    logic                      r_pom;
    logic                      r_auto;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [VALUE_W-1:0] r_prev, r_last;

    logic [1:0]                r_cmd;
    logic signed [VALUE_W-1:0] r_meas, r_man;
    logic [GAIN_W-1:0]         r_kp, r_ki, r_kd, r_ival;
    logic signed [DIFF_W-1:0]  r_err, r_dm;

    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [MUL_A_W-1:0] r_pterm;
    logic signed [INTEG_W-1:0] r_ni;
    logic [VALUE_W-1:0]        r_rem;
    logic [QUO_W-1:0]          r_quo;
    logic                      r_neg;
    logic [DIV_CNT_W-1:0]      r_cnt;
    t_out_item                 r_out;

    logic signed [MUL_A_W-1:0] m_a;
    logic signed [MUL_B_W-1:0] m_b;
    logic signed [PROD_W-1:0]  m_prod;
    logic signed [ACC_W-1:0]   lo_q, hi_q, lo_v, hi_v, cli_c, drv_c, man_c;
    logic [QUO_W:0]            mag;
    logic [VALUE_W:0]          shifted;
    logic                      qbit;
    logic signed [QUO_W:0]     dterm;
    logic signed [VALUE_W-1:0] drv;

    function automatic logic signed [ACC_W-1:0] clamp(
        input logic signed [ACC_W-1:0] x,
        input logic signed [ACC_W-1:0] lo,
        input logic signed [ACC_W-1:0] hi
    );
        if (x > hi) begin
            return hi;
        end else if (x < lo) begin
            return lo;
        end
        return x;
    endfunction

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (i_cmd.op)
            OP_MEI: begin
                m_a = {{(MUL_A_W-DIFF_W){r_err[DIFF_W-1]}}, r_err};
                m_b = {1'b0, r_ki};
            end
            OP_MIV: begin
                m_a = r_prod[MUL_A_W-1:0];
                m_b = {1'b0, r_ival};
            end
            OP_MKP: begin
                m_a = r_pom ? {{(MUL_A_W-DIFF_W){r_dm[DIFF_W-1]}}, r_dm}
                            : {{(MUL_A_W-DIFF_W){r_err[DIFF_W-1]}}, r_err};
                m_b = {1'b0, r_kp};
            end
            OP_MKD: begin
                m_a = {{(MUL_A_W-DIFF_W){r_dm[DIFF_W-1]}}, r_dm};
                m_b = {1'b0, r_kd};
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
        m_prod = m_a * m_b;
    end

    always_comb begin
        lo_q  = {{(ACC_W-INTEG_W){r_min[VALUE_W-1]}}, r_min, {FRAC_W{1'b0}}};
        hi_q  = {{(ACC_W-INTEG_W){r_max[VALUE_W-1]}}, r_max, {FRAC_W{1'b0}}};
        lo_v  = {{(ACC_W-VALUE_W){r_min[VALUE_W-1]}}, r_min};
        hi_v  = {{(ACC_W-VALUE_W){r_max[VALUE_W-1]}}, r_max};
        cli_c = clamp(r_acc, lo_q, hi_q);
        drv_c = clamp(r_acc >>> FRAC_W, lo_v, hi_v);
        man_c = clamp({{(ACC_W-VALUE_W){r_man[VALUE_W-1]}}, r_man}, lo_v, hi_v);
        drv   = drv_c[VALUE_W-1:0];
        mag   = r_prod[PROD_W-1] ? (QUO_W+1)'(-r_prod[QUO_W:0]) : r_prod[QUO_W:0];
        shifted = {r_rem, r_quo[QUO_W-1]};
        qbit    = (shifted >= {1'b0, r_ival});
        dterm   = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= '0;
            r_max   <= VALUE_W'(255);
            r_pom   <= 1'b0;
            r_auto  <= 1'b0;
            r_integ <= '0;
            r_prev  <= '0;
            r_last  <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OUT_MIN: r_min <= i_cfg_data;
                    CFG_OUT_MAX: r_max <= i_cfg_data;
                    CFG_P_ON_M:  r_pom <= i_cfg_data[0];
                    default:     ;
                endcase
            end
            if (i_cmd.op == OP_DVI) begin
                r_cnt <= '0;
            end else if (i_cmd.op == OP_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.op == OP_FIN) begin
                if (o_sts.compute) begin
                    r_integ <= r_ni;
                    r_last  <= drv;
                    r_prev  <= r_meas;
                end else if (r_cmd == CMD_AUTO) begin
                    if (!r_auto) begin
                        r_integ <= {man_c[VALUE_W-1:0], {FRAC_W{1'b0}}};
                        r_prev  <= r_meas;
                    end
                    r_auto <= 1'b1;
                end else if (r_cmd != CMD_COMPUTE) begin
                    r_auto <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_in.command;
            r_meas <= i_in.measurement;
            r_man  <= i_in.manual_output;
            r_kp   <= i_in.kp_gain;
            r_ki   <= i_in.ki_gain;
            r_kd   <= i_in.kd_gain;
            r_ival <= (i_in.interval == '0) ? GAIN_W'(1) : i_in.interval;
            r_err  <= {i_in.setpoint[VALUE_W-1], i_in.setpoint}
                    - {i_in.measurement[VALUE_W-1], i_in.measurement};
            r_dm   <= {i_in.measurement[VALUE_W-1], i_in.measurement}
                    - {r_prev[VALUE_W-1], r_prev};
        end
        case (i_cmd.op)
            OP_MEI, OP_MIV, OP_MKP: r_prod <= m_prod;
            OP_ADI: r_acc <= {{(ACC_W-INTEG_W){r_integ[INTEG_W-1]}}, r_integ}
                           + {r_prod[PROD_W-1], r_prod};
            OP_ADP: begin
                if (r_pom) begin
                    r_acc   <= r_acc - {r_prod[PROD_W-1], r_prod};
                    r_pterm <= '0;
                end else begin
                    r_pterm <= r_prod[MUL_A_W-1:0];
                end
            end
            OP_CLI: r_ni <= cli_c[INTEG_W-1:0];
            OP_MKD: begin
                r_prod <= m_prod;
                r_acc  <= {{(ACC_W-INTEG_W){r_ni[INTEG_W-1]}}, r_ni}
                        + {{(ACC_W-MUL_A_W){r_pterm[MUL_A_W-1]}}, r_pterm};
            end
            OP_DVI: begin
                r_neg <= r_prod[PROD_W-1];
                r_quo <= mag[QUO_W-1:0];
                r_rem <= '0;
            end
            OP_DIV: begin
                r_rem <= qbit ? VALUE_W'(shifted - {1'b0, r_ival}) : shifted[VALUE_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], qbit};
            end
            OP_OUT: r_acc <= r_acc - {{(ACC_W-QUO_W-1){dterm[QUO_W]}}, dterm};
            OP_FIN: begin
                if (o_sts.compute) begin
                    r_out.drive    <= drv;
                    r_out.computed <= 1'b1;
                end else begin
                    r_out.drive    <= r_last;
                    r_out.computed <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign o_sts.compute  = (r_cmd == CMD_COMPUTE) && r_auto;
    assign o_sts.div_done = (r_cnt == DIV_LAST);
    assign o_out          = r_out;

endmodule
`default_nettype wire

@@ rtl/pid_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pid_ctrl: PID step sequencer
// Steps the datapath through the multiply, clamp and divide sequence
// of one request and owns the request and result handshakes.
// ----------------------------------------------------------------------------
module pid_ctrl import pid_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_CHK  = 13'b0000000000010,
        S_MEI  = 13'b0000000000100,
        S_MIV  = 13'b0000000001000,
        S_ADI  = 13'b0000000010000,
        S_MKP  = 13'b0000000100000,
        S_ADP  = 13'b0000001000000,
        S_CLI  = 13'b0000010000000,
        S_MKD  = 13'b0000100000000,
        S_DVI  = 13'b0001000000000,
        S_DIV  = 13'b0010000000000,
        S_OUT  = 13'b0100000000000,
        S_FIN  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.op   = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_CHK: n_state = i_sts.compute ? S_MEI : S_FIN;
            S_MEI: begin
                o_cmd.op = OP_MEI;
                n_state  = S_MIV;
            end
            S_MIV: begin
                o_cmd.op = OP_MIV;
                n_state  = S_ADI;
            end
            S_ADI: begin
                o_cmd.op = OP_ADI;
                n_state  = S_MKP;
            end
            S_MKP: begin
                o_cmd.op = OP_MKP;
                n_state  = S_ADP;
            end
            S_ADP: begin
                o_cmd.op = OP_ADP;
                n_state  = S_CLI;
            end
            S_CLI: begin
                o_cmd.op = OP_CLI;
                n_state  = S_MKD;
            end
            S_MKD: begin
                o_cmd.op = OP_MKD;
                n_state  = S_DVI;
            end
            S_DVI: begin
                o_cmd.op = OP_DVI;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.op = OP_OUT;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.op = OP_FIN;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = (o_cmd.op == OP_FIN) || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted without the input side stalling");
    a_div_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_done) |=> (r_state == S_OUT))
        else $error("divider finished but sequence did not advance");
    a_fin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_FIN) |=> o_out_valid)
        else $error("result loaded without valid");
    a_fin_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && i_out_stall) |=> (r_state == S_FIN))
        else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

@@ rtl/pid_controller_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pid_controller_step: fixed-point PID step with anti-windup
//
//   Channel   Direction   Handshake               Payload
//   request   in          i_in_valid/o_in_stall   i_in  (t_in_item)
//   result    out         o_out_valid/i_out_stall o_out (t_out_item)
//   config    in          i_cfg_we                i_cfg_index, i_cfg_data
//
// A compute request in automatic mode goes through eleven sequencing, multiply
// and output steps and 32 steps of the restoring divider before its result is
// valid; other requests go from the check step straight to the final step. One
// request is in work at a time; the next is accepted in the cycle after the
// result is loaded at the earliest. Reset is synchronous and active low. A result
// waiting on a stalled output holds the sequencer in its final step.
// ----------------------------------------------------------------------------
module pid_controller_step import pid_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [VALUE_W-1:0]   i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    pid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    pid_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire
